[rtl/core/stack_sequence_checker_unit_defines.svh]
// ----------------------------------------------------------------------------
// Stack sequence checker assertion macros
// Shared property macros for the concurrent checks of the checker unit.
// ----------------------------------------------------------------------------
`ifndef STACK_SEQUENCE_CHECKER_UNIT_DEFINES_SVH
`define STACK_SEQUENCE_CHECKER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SSC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ssc check failed");

// Next-cycle implication, disabled while reset is high.
`define SSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ssc check failed");

`endif

[rtl/core/ssc_pkg.sv]
// ----------------------------------------------------------------------------
// Stack sequence checker package
// Field widths and the controller state type.
// ----------------------------------------------------------------------------
package ssc_pkg;

   localparam int unsigned VALUE_W = 11;

   typedef logic [VALUE_W-1:0] value_type;

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_PUSH    = 4'b0010,
      ST_COMPARE = 4'b0100,
      ST_WAIT    = 4'b1000
   } state_type;

endpackage

[rtl/core/ssc_stack_ram.sv]
// ----------------------------------------------------------------------------
// Stack storage
// Simple dual-port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ssc_stack_ram
   import ssc_pkg::*;
#(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  value_type         wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output value_type         rd_data
);

   value_type mem [DEPTH];
   value_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/stack_sequence_checker_unit.sv]
// ----------------------------------------------------------------------------
// Stack sequence checker unit
// Checks a wanted pop order against a stack fed with ascending values.
// ----------------------------------------------------------------------------
// Each request transaction names the next value of a wanted pop order. The
// unit pushes every number above the highest one pushed so far up to that
// value, then pops the top if it equals the value, and otherwise raises a
// sticky failure flag; restart clears the stack, the push counter and the
// flag before the transaction is handled. One response transaction follows
// every request. For a transaction that pushes nothing, the top is read
// from the stack memory speculatively while the unit is idle, and compared
// in the following cycle. A transaction that pushes values writes all but
// the requested one into the stack memory, which has one write port and
// takes one entry per cycle; the requested value is pushed and popped at
// once and is never written. A new request is taken only while the
// controller is idle, but a finished response may still be waiting in the
// output register then. The stack memory needs no clearing after reset.
// ----------------------------------------------------------------------------
`include "stack_sequence_checker_unit_defines.svh"

module stack_sequence_checker_unit
   import ssc_pkg::*;
#(
   parameter int MAX_VALUE = 1024
) (
   input  logic      clock,
   input  logic      reset,
   // request channel
   input  logic      req_valid,
   output logic      req_stall,
   input  value_type req_value,
   input  logic      req_restart,
   // response channel
   output logic      rsp_valid,
   input  logic      rsp_stall,
   output value_type rsp_push_count,
   output logic      rsp_popped,
   output logic      rsp_failed
);

   // The stack never holds more than MAX_VALUE entries, so the depth needs
   // one more code than the address.
   localparam int          ADDR_W      = $clog2(MAX_VALUE);
   localparam int          DEPTH_W     = $clog2(MAX_VALUE + 1);
   localparam logic [31:0] MAX_VALUE_U = 32'(MAX_VALUE);
   localparam logic [DEPTH_W-1:0] DEPTH_ONE = DEPTH_W'(1);
   localparam value_type   VALUE_ONE   = VALUE_W'(1);

   state_type          state_ff,      state_in;
   value_type          value_ff,      value_in;
   value_type          cnt_ff,        cnt_in;
   value_type          last_ff,       last_in;
   logic [DEPTH_W-1:0] depth_ff,      depth_in;
   logic               error_ff,      error_in;
   logic               can_pop_ff,    can_pop_in;
   value_type          count_ff,      count_in;
   logic               popped_ff,     popped_in;
   logic               rsp_valid_ff,  rsp_valid_in;
   value_type          rsp_count_ff,  rsp_count_in;
   logic               rsp_popped_ff, rsp_popped_in;
   logic               rsp_failed_ff, rsp_failed_in;

   logic               req_accept;
   logic               out_free;
   logic               in_range;
   value_type          eff_last;
   logic [DEPTH_W-1:0] eff_depth;
   logic               eff_error;
   logic               hit;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [DEPTH_W-1:0] top_index;
   logic [ADDR_W-1:0]  rd_addr;
   value_type          rd_data;

   // ------------------------------------------------------------------------
   // Stack memory. The read address always points at the current top, so
   // the top is ready in the cycle after a request is accepted.
   // ------------------------------------------------------------------------
   assign top_index = depth_ff - DEPTH_ONE;
   assign rd_addr   = top_index[ADDR_W-1:0];
   assign wr_addr   = depth_ff[ADDR_W-1:0];
   assign wr_en     = (state_ff == ST_PUSH) && (cnt_ff < value_ff);

   ssc_stack_ram #(
      .DEPTH  (MAX_VALUE),
      .ADDR_W (ADDR_W)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (cnt_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // ------------------------------------------------------------------------
   // Handshake and request decode.
   // ------------------------------------------------------------------------
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // Restart applies before the transaction, so decode against the cleared
   // state when it is set.
   assign eff_last  = req_restart ? '0 : last_ff;
   assign eff_depth = req_restart ? '0 : depth_ff;
   assign eff_error = req_restart ? 1'b0 : error_ff;
   assign in_range  = (req_value != '0) && (32'(req_value) <= MAX_VALUE_U);

   // A pop only succeeds when the stack holds something and the top matches.
   assign hit = can_pop_ff && (rd_data == value_ff);

   always_comb begin
      state_in      = state_ff;
      value_in      = value_ff;
      cnt_in        = cnt_ff;
      last_in       = last_ff;
      depth_in      = depth_ff;
      error_in      = error_ff;
      can_pop_in    = can_pop_ff;
      count_in      = count_ff;
      popped_in     = popped_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_count_in  = rsp_count_ff;
      rsp_popped_in = rsp_popped_ff;
      rsp_failed_in = rsp_failed_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               value_in   = req_value;
               last_in    = eff_last;
               depth_in   = eff_depth;
               error_in   = eff_error;
               can_pop_in = in_range && (eff_depth != '0);
               if (in_range && (req_value > eff_last)) begin
                  // Values above the last pushed one are pushed first; the
                  // requested value ends up on top and is popped at once.
                  cnt_in   = eff_last + VALUE_ONE;
                  count_in = req_value - eff_last;
                  state_in = ST_PUSH;
               end else begin
                  count_in = '0;
                  state_in = ST_COMPARE;
               end
            end
         end
         ST_PUSH: begin
            if (cnt_ff < value_ff) begin
               cnt_in   = cnt_ff + VALUE_ONE;
               depth_in = depth_ff + DEPTH_ONE;
            end else begin
               last_in   = value_ff;
               popped_in = 1'b1;
               if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_count_in  = count_ff;
                  rsp_popped_in = 1'b1;
                  rsp_failed_in = error_ff;
                  state_in      = ST_IDLE;
               end else begin
                  state_in = ST_WAIT;
               end
            end
         end
         ST_COMPARE: begin
            popped_in = hit;
            error_in  = error_ff || !hit;
            if (hit) begin
               depth_in = depth_ff - DEPTH_ONE;
            end
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_count_in  = count_ff;
               rsp_popped_in = hit;
               rsp_failed_in = error_ff || !hit;
               state_in      = ST_IDLE;
            end else begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            // The response is complete; hold it until the output slot frees.
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_count_in  = count_ff;
               rsp_popped_in = popped_ff;
               rsp_failed_in = error_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         last_ff      <= '0;
         depth_ff     <= '0;
         error_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_ff      <= last_in;
         depth_ff     <= depth_in;
         error_ff     <= error_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      value_ff      <= value_in;
      cnt_ff        <= cnt_in;
      can_pop_ff    <= can_pop_in;
      count_ff      <= count_in;
      popped_ff     <= popped_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_popped_ff <= rsp_popped_in;
      rsp_failed_ff <= rsp_failed_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_push_count = rsp_count_ff;
   assign rsp_popped     = rsp_popped_ff;
   assign rsp_failed     = rsp_failed_ff;

   // ------------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------------
   // Pushes never run past the end of the stack memory.
   `SSC_ASSERT_IMPLY(a_no_overflow, clock, reset, wr_en, 32'(depth_ff) < MAX_VALUE_U)
   // A transaction that pushed anything always pops its own value.
   `SSC_ASSERT_IMPLY(a_push_pops, clock, reset, rsp_valid && (rsp_push_count != '0), rsp_popped)
   // A failed pop leaves the sticky flag raised in the same response.
   `SSC_ASSERT_IMPLY(a_fail_sticky, clock, reset, rsp_valid && !rsp_popped, rsp_failed)
   // An accepted request always leaves the idle state.
   `SSC_ASSERT_NEXT(a_accept_busy, clock, reset, req_accept, req_stall)

endmodule

[tb/stack_sequence_checker_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Stack sequence checker unit testbench
// Drives wanted pop orders into the checker and compares every response
// transaction with a cycle-free model of the stack, the push counter and
// the sticky failure flag.
// ----------------------------------------------------------------------------
module stack_sequence_checker_unit_tb
   import ssc_pkg::*;
();

   localparam int MAX_VALUE      = 1024;
   localparam int RANDOM_ITEMS   = 1000;
   localparam int IDLE_PERCENT   = 18;
   // Stretch of cycles in which neither side idles.
   localparam int QUIET_FROM     = 3000;
   localparam int QUIET_TO       = 7000;
   // Long receiver hold-off, started once this many responses have arrived.
   localparam int HOLD_AFTER     = 100;
   localparam int HOLD_CYCLES    = 400;
   // The slowest transaction pushes 1024 values, and the receiver hold-off
   // stalls the output on top of that. The limit is taken well above both.
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 10;

   // A request as the sender offers it, and a response as it is expected.
   typedef struct packed {
      value_type value;
      logic      restart;
   } order_item_type;

   typedef struct packed {
      value_type push_count;
      logic      popped;
      logic      failed;
   } verdict_type;

   logic      clock       = 1'b0;
   logic      reset       = 1'b1;
   logic      req_valid   = 1'b0;
   logic      req_stall;
   value_type req_value   = '0;
   logic      req_restart = 1'b0;
   logic      rsp_valid;
   logic      rsp_stall   = 1'b0;
   value_type rsp_push_count;
   logic      rsp_popped;
   logic      rsp_failed;

   order_item_type pending_orders[$];
   verdict_type    expected_verdicts[$];
   int             order_buf[$];

   // Model state: the stack, the highest value pushed and the sticky flag.
   int          model_stack[MAX_VALUE];
   int          model_depth;
   int          model_last_pushed;
   bit          model_failed;

   int             cycle_count;
   int             idle_cycles;
   int             failures;
   int             orders_accepted;
   int             verdicts_seen;
   int             pop_total;
   int             miss_total;
   int             restart_total;
   int             longest_push_run;
   int             hold_left;
   bit             hold_started;
   order_item_type next_order;
   verdict_type    got_verdict;
   verdict_type    want_verdict;

   stack_sequence_checker_unit #(
      .MAX_VALUE(MAX_VALUE)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_value     (req_value),
      .req_restart   (req_restart),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_push_count(rsp_push_count),
      .rsp_popped    (rsp_popped),
      .rsp_failed    (rsp_failed)
   );

   always #5 clock = ~clock;

   // Random idling on either side, suppressed during the quiet stretch so
   // that back-to-back transactions are also exercised.
   function automatic bit take_gap();
      if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO) begin
         return 1'b0;
      end
      return $urandom_range(0, 99) < IDLE_PERCENT;
   endfunction

   // Works out the response for one request and advances the model state.
   // Every value above the last pushed one up to the requested one is pushed
   // first; then the top is popped if it equals the value. An empty stack,
   // a value of zero and a value above the maximum all count as a miss.
   function automatic verdict_type predict_stack_step(value_type value, logic restart);
      verdict_type result;
      int          want;
      int          pushes;
      bit          popped;
      want   = int'(value);
      pushes = 0;
      popped = 1'b0;
      if (restart) begin
         model_depth       = 0;
         model_last_pushed = 0;
         model_failed      = 1'b0;
         restart_total++;
      end
      if (want >= 1 && want <= MAX_VALUE) begin
         while (model_last_pushed < want) begin
            model_last_pushed++;
            if (model_depth < MAX_VALUE) begin
               model_stack[model_depth] = model_last_pushed;
               model_depth++;
            end
            pushes++;
         end
         if (model_depth > 0 && model_stack[model_depth-1] == want) begin
            model_depth--;
            popped = 1'b1;
         end
      end
      if (!popped) begin
         model_failed = 1'b1;
         miss_total++;
      end else begin
         pop_total++;
      end
      if (pushes > longest_push_run) begin
         longest_push_run = pushes;
      end
      result.push_count = value_type'(pushes);
      result.popped     = popped;
      result.failed     = model_failed;
      return result;
   endfunction

   task automatic add_order(input int value, input bit restart);
      order_item_type item;
      item.value   = value_type'(value);
      item.restart = restart;
      pending_orders.push_back(item);
   endtask

   // Builds a pop order of 1..n that a stack fed in ascending order can
   // produce, by pushing and popping at random.
   task automatic make_pop_order(input int n);
      int next_val;
      int stk[$];
      order_buf.delete();
      next_val = 1;
      while (order_buf.size() < n) begin
         if (next_val <= n && (stk.size() == 0 || $urandom_range(0, 1) == 1)) begin
            stk.push_back(next_val);
            next_val++;
         end else begin
            order_buf.push_back(stk.pop_back());
         end
      end
   endtask

   // Breaks a well-formed order: swap two entries, replace one, or drop one.
   task automatic spoil_pop_order(input int n);
      int i;
      int j;
      int tmp;
      i = $urandom_range(0, order_buf.size() - 1);
      j = $urandom_range(0, order_buf.size() - 1);
      case ($urandom_range(0, 2))
         0: begin
            tmp          = order_buf[i];
            order_buf[i] = order_buf[j];
            order_buf[j] = tmp;
         end
         1: begin
            if ($urandom_range(0, 3) == 0) begin
               order_buf[i] = $urandom_range(0, 2047);
            end else begin
               order_buf[i] = $urandom_range(0, n + 3);
            end
         end
         default: begin
            if (order_buf.size() > 1) begin
               order_buf.delete(i);
            end
         end
      endcase
   endtask

   // Stimulus: the directed cases first, then random pop orders, mostly
   // well-formed, with broken orders and loose noise mixed in.
   initial begin : stimulus
      int random_items;
      int pick;
      int n;
      int k;
      int burst;
      int total_orders;

      // A single push and pop, then a compare against an empty stack.
      add_order(1, 1'b1);
      add_order(1, 1'b0);
      // Failure flag is sticky across a good pop.
      add_order(3, 1'b0);
      // Restart clears the flag before the transaction is handled.
      add_order(2, 1'b1);
      // Value zero can never match.
      add_order(0, 1'b0);
      add_order(1, 1'b1);
      // Values above the maximum push nothing; every value bit set.
      add_order(2047, 1'b0);
      add_order(1025, 1'b1);
      // Largest push run, then values at or below the last pushed one.
      add_order(1024, 1'b1);
      add_order(1023, 1'b0);
      add_order(1, 1'b0);
      add_order(1024, 1'b0);
      // A short order with a mismatching top in the middle.
      add_order(5, 1'b1);
      add_order(4, 1'b0);
      add_order(2, 1'b0);
      add_order(3, 1'b0);
      add_order(2, 1'b0);
      add_order(1, 1'b0);
      add_order(1, 1'b0);
      // Alternating bit patterns, one in range and one above it.
      add_order(682, 1'b1);
      add_order(1365, 1'b0);

      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if ($urandom_range(0, 24) == 0) begin
            n = $urandom_range(50, 300);
         end else begin
            n = $urandom_range(1, 20);
         end
         if (pick < 90) begin
            make_pop_order(n);
            if (pick >= 80) begin
               spoil_pop_order(n);
            end
            for (k = 0; k < order_buf.size(); k++) begin
               if (k == 0) begin
                  add_order(order_buf[k], $urandom_range(0, 9) != 0);
               end else begin
                  add_order(order_buf[k], $urandom_range(0, 199) == 0);
               end
            end
            random_items += order_buf.size();
         end else begin
            burst = $urandom_range(1, 5);
            for (k = 0; k < burst; k++) begin
               if ($urandom_range(0, 9) == 0) begin
                  add_order($urandom_range(0, 2047), $urandom_range(0, 7) == 0);
               end else begin
                  add_order($urandom_range(0, 40), $urandom_range(0, 7) == 0);
               end
            end
            random_items += burst;
         end
      end
      total_orders = pending_orders.size();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Wait until a response has come back for every request.
      @(posedge clock);
      while (verdicts_seen < total_orders) begin
         @(posedge clock);
      end
      // Keep watching the output to catch any stray response transaction.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_verdicts.size() != 0) begin
         $error("%0d expected responses never arrived", expected_verdicts.size());
         failures++;
      end

      $display("Checked %0d request transactions in %0d cycles:",
               orders_accepted, cycle_count);
      $display("%0d pops, %0d misses, %0d restarts, longest push run %0d values.",
               pop_total, miss_total, restart_total, longest_push_run);
      $display("Receiver held off once for %0d cycles.", HOLD_CYCLES);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Driver: offers the next pending request once the current one has been
   // taken. A stalled transaction is held unchanged.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (pending_orders.size() != 0 && !take_gap()) begin
            next_order  = pending_orders.pop_front();
            req_valid   <= 1'b1;
            req_value   <= next_order.value;
            req_restart <= next_order.restart;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor and receiver: predicts on every accepted request, checks every
   // accepted response against the oldest prediction, and drives the
   // response stall, including the one long hold-off that lets the unit
   // fill up and stall its request side.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_verdicts.push_back(predict_stack_step(req_value, req_restart));
            orders_accepted++;
         end
         if (rsp_valid && !rsp_stall) begin
            verdicts_seen++;
            got_verdict.push_count = rsp_push_count;
            got_verdict.popped     = rsp_popped;
            got_verdict.failed     = rsp_failed;
            if (expected_verdicts.size() == 0) begin
               $error("response transaction with no request outstanding");
               failures++;
            end else begin
               want_verdict = expected_verdicts.pop_front();
               if (got_verdict.push_count !== want_verdict.push_count) begin
                  $error("push_count: expected %0d, actual %0d",
                         want_verdict.push_count, got_verdict.push_count);
                  failures++;
               end
               if (got_verdict.popped !== want_verdict.popped) begin
                  $error("popped: expected %0b, actual %0b",
                         want_verdict.popped, got_verdict.popped);
                  failures++;
               end
               if (got_verdict.failed !== want_verdict.failed) begin
                  $error("failed: expected %0b, actual %0b",
                         want_verdict.failed, got_verdict.failed);
                  failures++;
               end
            end
         end
         if (!hold_started && verdicts_seen >= HOLD_AFTER) begin
            hold_started = 1'b1;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= take_gap();
         end
      end
   end

   // Watchdog: ends the run when nothing has been accepted for too long.
   always @(posedge clock) begin
      cycle_count++;
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $error("no transaction accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/ssc_pkg.sv
rtl/core/ssc_stack_ram.sv
rtl/core/stack_sequence_checker_unit.sv
tb/stack_sequence_checker_unit_tb.sv
